>>> hw/rtl/ssps_pkg.sv
// ============================================================================
// Sleep-state power sequencer package
// Shared widths, codes, register reset values and the structs passed between
// the top level and the step logic.
// ============================================================================
package ssps_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int REG_W       = 20;
    localparam int CMP_W       = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam int STATE_W     = 4;
    localparam int PHASE_W     = 3;
    localparam int RAILS_W     = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [RAILS_W-1:0] RAIL_ALWAYS_ON = 8'h01;
    localparam logic [RAILS_W-1:0] RAIL_NONCORE   = 8'h3E;
    localparam logic [RAILS_W-1:0] RAIL_CPU_CORE  = 8'h40;
    localparam logic [RAILS_W-1:0] RAIL_GFX_CORE  = 8'h80;

    localparam logic [REG_W-1:0] WAIT_TIMEOUT_RST = 20'd1000000;
    localparam logic [REG_W-1:0] AON_SETTLE_RST   = 20'd10000;
    localparam logic [REG_W-1:0] SUSCLK_RST       = 20'd5000;
    localparam logic [REG_W-1:0] PWROK_DELAY_RST  = 20'd99000;

    localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_3 = 3'd3;

    typedef enum logic [STATE_W-1:0] {
        ST_G3   = 4'd0,
        ST_S5   = 4'd1,
        ST_S3   = 4'd2,
        ST_S0   = 4'd3,
        ST_G3S5 = 4'd4,
        ST_S5S3 = 4'd5,
        ST_S3S0 = 4'd6,
        ST_S0S3 = 4'd7,
        ST_S3S5 = 4'd8
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAIT_TIMEOUT = 2'd0,
        CFG_AON_SETTLE   = 2'd1,
        CFG_SUSCLK       = 2'd2,
        CFG_PWROK_DELAY  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic swok;
        logic ddren;
        logic shunt;
        logic rcin;
        logic switched;
        logic fan;
        logic core;
        logic pwrok;
    } ctrl_t;

    typedef struct packed {
        state_t                   state;
        logic [PHASE_W-1:0]       phase;
        logic [COUNT_WIDTH-1:0]   count;
        ctrl_t                    ctrl;
    } seq_t;

    typedef struct packed {
        logic [REG_W-1:0] wait_timeout;
        logic [REG_W-1:0] aon_settle;
        logic [REG_W-1:0] susclk_settle;
        logic [REG_W-1:0] pwrok_delay;
    } cfg_t;

    typedef struct packed {
        logic [RAILS_W-1:0] rails_good;
        logic               slp_s3_n;
        logic               slp_s5_n;
        logic               suswarn_n;
        logic               backlight_request;
    } sample_t;

endpackage

>>> hw/rtl/sleep_state_power_sequencer_core.sv
// ============================================================================
// Sleep-state power sequencer core
// Steps G3/S5/S3/S0 power sequencing, one microsecond tick per transaction.
// ============================================================================
// Timing: an accepted sample is held in the sample register and moves into the
// result register once that register is empty or being drained.
// Throughput: one transaction per cycle while the result receiver keeps up; the
// sequencer state is updated as a sample moves into the result register.
// Reset: asynchronous, active low; state G3, phase 0, count 0, all control
// lines low (rcin_n too), configuration registers at their default values.
module sleep_state_power_sequencer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [ssps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssps_pkg::REG_W-1:0]        cfg_wdata,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ssps_pkg::RAILS_W-1:0]      rails_good,
    input  logic                              slp_s3_n,
    input  logic                              slp_s5_n,
    input  logic                              suswarn_n,
    input  logic                              backlight_request,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ssps_pkg::STATE_W-1:0]      power_state,
    output logic                              suspend_well_ok,
    output logic                              ddr_enable,
    output logic                              ddr_shunt,
    output logic                              rcin_n,
    output logic                              switched_rails_enable,
    output logic                              fan_enable,
    output logic                              core_rails_enable,
    output logic                              chipset_pwrok,
    output logic                              susack_n,
    output logic                              backlight_enable,
    output logic                              timeout_flag
);
    import ssps_pkg::*;

    // Configuration registers
    cfg_t    cfg_reg;

    // Sample stage
    logic    s1_valid_reg;
    logic    s1_valid_next;
    sample_t s1_data_reg;

    // Sequencer state
    seq_t    seq_reg;
    seq_t    seq_next;
    logic    step_timeout;

    // Result stage
    logic    out_valid_reg;
    logic    out_valid_next;
    seq_t    res_seq_reg;
    logic    res_susack_reg;
    logic    res_backlight_reg;
    logic    res_timeout_reg;

    // Handshake
    logic    s2_load;
    logic    s1_fire;
    logic    in_fire;

    // Result register can take a new transaction when empty or being drained
    assign s2_load  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s2_load;
    assign in_ready = !s1_valid_reg || s2_load;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    // Configuration writes: the full written word goes to the indexed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_timeout  <= WAIT_TIMEOUT_RST;
            cfg_reg.aon_settle    <= AON_SETTLE_RST;
            cfg_reg.susclk_settle <= SUSCLK_RST;
            cfg_reg.pwrok_delay   <= PWROK_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WAIT_TIMEOUT: cfg_reg.wait_timeout  <= cfg_wdata;
                CFG_AON_SETTLE:   cfg_reg.aon_settle    <= cfg_wdata;
                CFG_SUSCLK:       cfg_reg.susclk_settle <= cfg_wdata;
                CFG_PWROK_DELAY:  cfg_reg.pwrok_delay   <= cfg_wdata;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Capture the sampled pins of each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg.rails_good        <= rails_good;
            s1_data_reg.slp_s3_n          <= slp_s3_n;
            s1_data_reg.slp_s5_n          <= slp_s5_n;
            s1_data_reg.suswarn_n         <= suswarn_n;
            s1_data_reg.backlight_request <= backlight_request;
        end
    end

    ssps_step u_step (
        .cur     (seq_reg),
        .cfg     (cfg_reg),
        .smp     (s1_data_reg),
        .nxt     (seq_next),
        .timeout (step_timeout)
    );

    // Control: valid bits and the sequencer state; advance the sequencer only
    // when the sample moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg.state <= ST_G3;
            seq_reg.phase <= PH_0;
            seq_reg.count <= '0;
            seq_reg.ctrl  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                seq_reg <= seq_next;
            end
        end
    end

    // Result payload: hold while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_seq_reg       <= seq_next;
            res_susack_reg    <= s1_data_reg.suswarn_n;
            res_backlight_reg <= s1_data_reg.backlight_request;
            res_timeout_reg   <= step_timeout;
        end
    end

    assign out_valid             = out_valid_reg;
    assign power_state           = res_seq_reg.state;
    assign suspend_well_ok       = res_seq_reg.ctrl.swok;
    assign ddr_enable            = res_seq_reg.ctrl.ddren;
    assign ddr_shunt             = res_seq_reg.ctrl.shunt;
    assign rcin_n                = res_seq_reg.ctrl.rcin;
    assign switched_rails_enable = res_seq_reg.ctrl.switched;
    assign fan_enable            = res_seq_reg.ctrl.fan;
    assign core_rails_enable     = res_seq_reg.ctrl.core;
    assign chipset_pwrok         = res_seq_reg.ctrl.pwrok;
    assign susack_n              = res_susack_reg;
    assign backlight_enable      = res_backlight_reg;
    assign timeout_flag          = res_timeout_reg;

`ifndef ASSERT_OFF
    // Sequencer must not move unless a transaction is stepped
    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(seq_reg))
        else $error("sequencer state changed without a stepped transaction");

    // A rail timeout only happens in the states that wait for rails
    a_timeout_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timeout_flag) |->
            (power_state == ST_G3S5 || power_state == ST_S3S0))
        else $error("timeout flagged outside a rail wait");

    // Power ok to the chipset requires the core rails enabled
    a_pwrok_core: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chipset_pwrok) |-> core_rails_enable)
        else $error("chipset power ok without core rails");

    // Memory rail enable and shunt are never on together
    a_ddr_shunt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(ddr_enable && ddr_shunt))
        else $error("memory rail enabled while shunted");
`endif

endmodule

>>> hw/rtl/ssps_step.sv
// ============================================================================
// Sleep-state power sequencer step logic
// Next sequencer state, phase, tick count and control lines for one tick.
// ============================================================================
module ssps_step (
    input  ssps_pkg::seq_t    cur,
    input  ssps_pkg::cfg_t    cfg,
    input  ssps_pkg::sample_t smp,
    output ssps_pkg::seq_t    nxt,
    output logic              timeout
);
    import ssps_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   cnt_sat;

    // Delay or timeout ends when the bumped count reaches len or saturates
    function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
                                     input logic [REG_W-1:0]       len);
        reached = (CMP_W'(cnt) >= CMP_W'(len)) || (cnt == CNT_MAX);
    endfunction

    function automatic logic rails_met(input logic [RAILS_W-1:0] rails,
                                       input logic [RAILS_W-1:0] want);
        rails_met = ((rails & want) == want);
    endfunction

    assign cnt_sat = (cur.count == CNT_MAX);
    assign cnt_inc = cnt_sat ? cur.count : cur.count + COUNT_WIDTH'(1);

    always_comb
    begin
        nxt     = cur;
        timeout = 1'b0;
        case (cur.state)
            ST_G3S5:
            begin
                if (cur.phase == PH_1)
                begin
                    nxt.count = cnt_inc;
                    if (reached(cnt_inc, cfg.aon_settle))
                    begin
                        nxt.ctrl.swok = 1'b1;
                        nxt.phase     = PH_2;
                        nxt.count     = '0;
                    end
                end
                else if (cur.phase == PH_2)
                begin
                    nxt.count = cnt_inc;
                    if (reached(cnt_inc, cfg.susclk_settle))
                    begin
                        nxt.state = ST_S5;
                        nxt.phase = PH_0;
                        nxt.count = '0;
                    end
                end
                else
                begin
                    if (rails_met(smp.rails_good, RAIL_ALWAYS_ON))
                    begin
                        nxt.phase = PH_1;
                        nxt.count = '0;
                    end
                    else if (reached(cnt_inc, cfg.wait_timeout))
                    begin
                        timeout   = 1'b1;
                        nxt.phase = PH_1;
                        nxt.count = '0;
                    end
                    else
                    begin
                        nxt.count = cnt_inc;
                    end
                end
            end
            ST_S5:
            begin
                if (smp.slp_s5_n)
                begin
                    nxt.state = ST_S5S3;
                    nxt.phase = PH_0;
                    nxt.count = '0;
                end
            end
            ST_S5S3:
            begin
                nxt.ctrl.shunt = 1'b0;
                nxt.ctrl.ddren = 1'b1;
                nxt.state      = ST_S3;
                nxt.phase      = PH_0;
                nxt.count      = '0;
            end
            ST_S3:
            begin
                if (smp.slp_s3_n)
                begin
                    nxt.state = ST_S3S0;
                    nxt.phase = PH_0;
                    nxt.count = '0;
                end
                else if (!smp.slp_s5_n)
                begin
                    nxt.state = ST_S3S5;
                    nxt.phase = PH_0;
                    nxt.count = '0;
                end
            end
            ST_S3S0:
            begin
                if (cur.phase == PH_1)
                begin
                    if (rails_met(smp.rails_good, RAIL_NONCORE))
                    begin
                        nxt.ctrl.core = 1'b1;
                        nxt.phase     = PH_2;
                        nxt.count     = '0;
                    end
                    else if (reached(cnt_inc, cfg.wait_timeout))
                    begin
                        timeout       = 1'b1;
                        nxt.ctrl.core = 1'b1;
                        nxt.phase     = PH_2;
                        nxt.count     = '0;
                    end
                    else
                    begin
                        nxt.count = cnt_inc;
                    end
                end
                else if (cur.phase == PH_2)
                begin
                    if (rails_met(smp.rails_good,
                                  RAIL_NONCORE | RAIL_CPU_CORE | RAIL_GFX_CORE))
                    begin
                        nxt.phase = PH_3;
                        nxt.count = '0;
                    end
                    else if (reached(cnt_inc, cfg.wait_timeout))
                    begin
                        timeout   = 1'b1;
                        nxt.phase = PH_3;
                        nxt.count = '0;
                    end
                    else
                    begin
                        nxt.count = cnt_inc;
                    end
                end
                else if (cur.phase == PH_3)
                begin
                    nxt.count = cnt_inc;
                    if (reached(cnt_inc, cfg.pwrok_delay))
                    begin
                        nxt.ctrl.pwrok = 1'b1;
                        nxt.state      = ST_S0;
                        nxt.phase      = PH_0;
                        nxt.count      = '0;
                    end
                end
                else
                begin
                    nxt.ctrl.rcin     = 1'b1;
                    nxt.ctrl.switched = 1'b1;
                    nxt.ctrl.fan      = 1'b1;
                    nxt.phase         = PH_1;
                    nxt.count         = '0;
                end
            end
            ST_S0:
            begin
                if (!smp.slp_s3_n)
                begin
                    nxt.state = ST_S0S3;
                    nxt.phase = PH_0;
                    nxt.count = '0;
                end
            end
            ST_S0S3:
            begin
                if (cur.phase == PH_1)
                begin
                    nxt.ctrl.core     = 1'b0;
                    nxt.ctrl.rcin     = 1'b0;
                    nxt.ctrl.fan      = 1'b0;
                    nxt.ctrl.switched = 1'b0;
                    nxt.state         = ST_S3;
                    nxt.phase         = PH_0;
                    nxt.count         = '0;
                end
                else
                begin
                    nxt.ctrl.pwrok = 1'b0;
                    nxt.phase      = PH_1;
                    nxt.count      = '0;
                end
            end
            ST_S3S5:
            begin
                nxt.ctrl.ddren = 1'b0;
                nxt.ctrl.shunt = 1'b1;
                nxt.state      = ST_S5;
                nxt.phase      = PH_0;
                nxt.count      = '0;
            end
            default:
            begin
                // G3 and unused codes start the G3 to S5 sequence
                nxt.state = ST_G3S5;
                nxt.phase = PH_0;
                nxt.count = '0;
            end
        endcase
    end

endmodule

>>> sim/tb_top.sv
// ============================================================================
// Sleep-state power sequencer core testbench
// Drives one sampled tick of rail power-good bits and chipset sleep lines per
// transaction and scores every result against a cycle-free predictor of the
// G3/S5/S3/S0 sequencer. A table of directed ticks and register writes comes
// first, then phases of random sleep-level sequences under changing register
// settings, with bursty input traffic and a stalling result receiver.
// ============================================================================
module tb_top;
    import ssps_pkg::*;

    // One result transaction, in port order
    typedef struct packed {
        state_t state;
        ctrl_t  ctrl;
        logic   susack_n;
        logic   backlight;
        logic   timeout;
    } tick_result_t;

    // Outcome of one tick spent waiting on power-good rails
    typedef enum logic [1:0] {
        WAIT_HOLD,
        WAIT_MET,
        WAIT_EXPIRED
    } rail_wait_t;

    // One row of the directed table: either a register write or a tick
    typedef struct {
        logic             is_write;
        cfg_idx_t         reg_index;
        logic [REG_W-1:0] reg_value;
        sample_t          sample;
        logic             typed;
        tick_result_t     result;
    } plan_row_t;

    localparam int RANDOM_PHASES   = 10;
    localparam int TICKS_PER_PHASE = 110;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;

    // ------------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                   clk               = 1'b0;
    logic                   rst_n             = 1'b0;
    logic                   cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index         = '0;
    logic [REG_W-1:0]       cfg_wdata         = '0;
    logic                   in_valid          = 1'b0;
    logic [RAILS_W-1:0]     rails_good        = '0;
    logic                   slp_s3_n          = 1'b0;
    logic                   slp_s5_n          = 1'b0;
    logic                   suswarn_n         = 1'b0;
    logic                   backlight_request = 1'b0;
    logic                   out_ready         = 1'b0;

    logic                   in_ready;
    logic                   out_valid;
    logic [STATE_W-1:0]     power_state;
    logic                   suspend_well_ok;
    logic                   ddr_enable;
    logic                   ddr_shunt;
    logic                   rcin_n;
    logic                   switched_rails_enable;
    logic                   fan_enable;
    logic                   core_rails_enable;
    logic                   chipset_pwrok;
    logic                   susack_n;
    logic                   backlight_enable;
    logic                   timeout_flag;

    sleep_state_power_sequencer_core u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .rails_good            (rails_good),
        .slp_s3_n              (slp_s3_n),
        .slp_s5_n              (slp_s5_n),
        .suswarn_n             (suswarn_n),
        .backlight_request     (backlight_request),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .power_state           (power_state),
        .suspend_well_ok       (suspend_well_ok),
        .ddr_enable            (ddr_enable),
        .ddr_shunt             (ddr_shunt),
        .rcin_n                (rcin_n),
        .switched_rails_enable (switched_rails_enable),
        .fan_enable            (fan_enable),
        .core_rails_enable     (core_rails_enable),
        .chipset_pwrok         (chipset_pwrok),
        .susack_n              (susack_n),
        .backlight_enable      (backlight_enable),
        .timeout_flag          (timeout_flag)
    );

    // 20-unit clock period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer predictor: its own copy of the state and the registers
    // ------------------------------------------------------------------------
    state_t                 seq_state;
    logic [PHASE_W-1:0]     seq_phase;
    logic [COUNT_WIDTH-1:0] seq_count;
    ctrl_t                  seq_ctrl;
    logic [REG_W-1:0]       timeout_ticks;
    logic [REG_W-1:0]       aon_settle_ticks;
    logic [REG_W-1:0]       susclk_ticks;
    logic [REG_W-1:0]       pwrok_ticks;

    tick_result_t           expected_ticks[$];

    int                     ticks_sent      = 0;
    int                     results_checked = 0;
    int                     timeouts_seen   = 0;
    int                     reg_writes      = 0;
    int                     fail_count      = 0;
    int                     burst_left      = 0;

    // Enter a new state and phase; every entry restarts the tick counter
    function automatic void move_to(state_t st, logic [PHASE_W-1:0] ph);
        seq_state = st;
        seq_phase = ph;
        seq_count = '0;
    endfunction

    // Advance the counter, saturating at its top value
    function automatic void count_tick();
        if (seq_count != CNT_MAX)
            seq_count = seq_count + 1'b1;
    endfunction

    // Fixed delay: done on the tick the advanced count reaches the length
    function automatic logic settled(logic [REG_W-1:0] len);
        count_tick();
        return (seq_count >= len) || (seq_count == CNT_MAX);
    endfunction

    // Rail wait: met at once when all wanted rails are good, else count on
    function automatic rail_wait_t rails_ready(logic [RAILS_W-1:0] rails,
                                               logic [RAILS_W-1:0] want);
        if ((rails & want) == want)
            return WAIT_MET;
        count_tick();
        if ((seq_count >= timeout_ticks) || (seq_count == CNT_MAX))
            return WAIT_EXPIRED;
        return WAIT_HOLD;
    endfunction

    // Advance the sequencer by one tick and return the lines it then drives
    function automatic tick_result_t step_sequencer(sample_t s);
        rail_wait_t w;
        logic       tflag;
        tflag = 1'b0;
        case (seq_state)
            ST_G3S5:
            begin
                if (seq_phase == PH_1)
                begin
                    if (settled(aon_settle_ticks))
                    begin
                        seq_ctrl.swok = 1'b1;
                        move_to(ST_G3S5, PH_2);
                    end
                end
                else if (seq_phase == PH_2)
                begin
                    if (settled(susclk_ticks))
                        move_to(ST_S5, PH_0);
                end
                else
                begin
                    w = rails_ready(s.rails_good, RAIL_ALWAYS_ON);
                    if (w != WAIT_HOLD)
                    begin
                        tflag = (w == WAIT_EXPIRED);
                        move_to(ST_G3S5, PH_1);
                    end
                end
            end
            ST_S5:
            begin
                if (s.slp_s5_n)
                    move_to(ST_S5S3, PH_0);
            end
            ST_S5S3:
            begin
                seq_ctrl.shunt = 1'b0;
                seq_ctrl.ddren = 1'b1;
                move_to(ST_S3, PH_0);
            end
            ST_S3:
            begin
                if (s.slp_s3_n)
                    move_to(ST_S3S0, PH_0);
                else if (!s.slp_s5_n)
                    move_to(ST_S3S5, PH_0);
            end
            ST_S3S0:
            begin
                if (seq_phase == PH_1)
                begin
                    w = rails_ready(s.rails_good, RAIL_NONCORE);
                    if (w != WAIT_HOLD)
                    begin
                        tflag = (w == WAIT_EXPIRED);
                        seq_ctrl.core = 1'b1;
                        move_to(ST_S3S0, PH_2);
                    end
                end
                else if (seq_phase == PH_2)
                begin
                    w = rails_ready(s.rails_good,
                                    RAIL_NONCORE | RAIL_CPU_CORE | RAIL_GFX_CORE);
                    if (w != WAIT_HOLD)
                    begin
                        tflag = (w == WAIT_EXPIRED);
                        move_to(ST_S3S0, PH_3);
                    end
                end
                else if (seq_phase == PH_3)
                begin
                    if (settled(pwrok_ticks))
                    begin
                        seq_ctrl.pwrok = 1'b1;
                        move_to(ST_S0, PH_0);
                    end
                end
                else
                begin
                    seq_ctrl.rcin     = 1'b1;
                    seq_ctrl.switched = 1'b1;
                    seq_ctrl.fan      = 1'b1;
                    move_to(ST_S3S0, PH_1);
                end
            end
            ST_S0:
            begin
                if (!s.slp_s3_n)
                    move_to(ST_S0S3, PH_0);
            end
            ST_S0S3:
            begin
                if (seq_phase == PH_1)
                begin
                    seq_ctrl.core     = 1'b0;
                    seq_ctrl.rcin     = 1'b0;
                    seq_ctrl.fan      = 1'b0;
                    seq_ctrl.switched = 1'b0;
                    move_to(ST_S3, PH_0);
                end
                else
                begin
                    seq_ctrl.pwrok = 1'b0;
                    move_to(ST_S0S3, PH_1);
                end
            end
            ST_S3S5:
            begin
                seq_ctrl.ddren = 1'b0;
                seq_ctrl.shunt = 1'b1;
                move_to(ST_S5, PH_0);
            end
            default:
                move_to(ST_G3S5, PH_0);
        endcase
        return '{seq_state, seq_ctrl, s.suswarn_n, s.backlight_request, tflag};
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    function automatic plan_row_t tick_row(logic [RAILS_W-1:0] rails, logic s3n,
                                           logic s5n, logic warn, logic blt);
        plan_row_t r;
        r.is_write  = 1'b0;
        r.reg_index = CFG_WAIT_TIMEOUT;
        r.reg_value = '0;
        r.sample    = '{rails, s3n, s5n, warn, blt};
        r.typed     = 1'b0;
        r.result    = '0;
        return r;
    endfunction

    function automatic plan_row_t checked_row(logic [RAILS_W-1:0] rails, logic s3n,
                                              logic s5n, logic warn, logic blt,
                                              tick_result_t want);
        plan_row_t r;
        r        = tick_row(rails, s3n, s5n, warn, blt);
        r.typed  = 1'b1;
        r.result = want;
        return r;
    endfunction

    function automatic plan_row_t write_row(cfg_idx_t idx, logic [REG_W-1:0] value);
        plan_row_t r;
        r           = tick_row('0, 1'b0, 1'b0, 1'b0, 1'b0);
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Write one register with the block idle; drop the enable after the writing edge
    task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WAIT_TIMEOUT: timeout_ticks    = value;
            CFG_AON_SETTLE:   aon_settle_ticks = value;
            CFG_SUSCLK:       susclk_ticks     = value;
            CFG_PWROK_DELAY:  pwrok_ticks      = value;
            default:          ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // Present one tick, hold it until the transaction is taken, then predict.
    // Valid stays high on return; the caller decides whether to drop it.
    task automatic drive_tick(sample_t s, logic typed, tick_result_t typed_result);
        tick_result_t predicted;
        in_valid          <= 1'b1;
        rails_good        <= s.rails_good;
        slp_s3_n          <= s.slp_s3_n;
        slp_s5_n          <= s.slp_s5_n;
        suswarn_n         <= s.suswarn_n;
        backlight_request <= s.backlight_request;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_sequencer(s);
        expected_ticks.push_back(typed ? typed_result : predicted);
        ticks_sent++;
    endtask

    // Bursty sender: at the end of each burst, mostly drop valid for a random gap
    task automatic pace();
        int gap;
        if (burst_left != 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: a free-running counter picks the receiver's stall pattern
    // (always ready, coin flip, one cycle in four, mostly ready)
    // ------------------------------------------------------------------------
    logic [7:0] stall_tick = '0;

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[7:6])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= (stall_tick[1:0] == 2'd0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Score each result transaction against the oldest prediction
    always @(posedge clk)
    begin : check_results
        tick_result_t seen;
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{state_t'(power_state),
                     '{suspend_well_ok, ddr_enable, ddr_shunt, rcin_n,
                       switched_rails_enable, fan_enable, core_rails_enable,
                       chipset_pwrok},
                     susack_n, backlight_enable, timeout_flag};
            if (expected_ticks.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with no tick outstanding: state %0d ctrl %h",
                             $realtime, seen.state, seen.ctrl);
            end
            else
            begin
                want = expected_ticks.pop_front();
                results_checked++;
                if (want.timeout)
                    timeouts_seen++;
                if (seen !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: tick %0d mismatch: state %0d/%0d ctrl %h/%h ",
                                  "susack %b/%b backlight %b/%b timeout %b/%b ",
                                  "(expected/actual)"},
                                 $realtime, results_checked,
                                 want.state, seen.state, want.ctrl, seen.ctrl,
                                 want.susack_n, seen.susack_n,
                                 want.backlight, seen.backlight,
                                 want.timeout, seen.timeout);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        plan_row_t        plan[$];
        sample_t          s;
        int               target;
        int               phase;
        int               n;
        logic [REG_W-1:0] t_val;
        logic [REG_W-1:0] p_val;
        logic [REG_W-1:0] aon_val;
        logic [REG_W-1:0] sus_val;

        // Predictor comes out of reset with the block
        seq_state        = ST_G3;
        seq_phase        = PH_0;
        seq_count        = '0;
        seq_ctrl         = '0;
        timeout_ticks    = WAIT_TIMEOUT_RST;
        aon_settle_ticks = AON_SETTLE_RST;
        susclk_ticks     = SUSCLK_RST;
        pwrok_ticks      = PWROK_DELAY_RST;
        target           = 0;

        // Out of reset: G3 leaves at once, then the always-on wait counts
        plan.push_back(checked_row(8'h00, 1'b0, 1'b0, 1'b1, 1'b0,
                       '{ST_G3S5, ctrl_t'(8'h00), 1'b1, 1'b0, 1'b0}));
        plan.push_back(checked_row(8'hFE, 1'b0, 1'b0, 1'b0, 1'b1,
                       '{ST_G3S5, ctrl_t'(8'h00), 1'b0, 1'b1, 1'b0}));
        // Shorten the timeout mid-wait: it counts from the start of the wait
        plan.push_back(write_row(CFG_WAIT_TIMEOUT, 20'd2));
        plan.push_back(checked_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                       '{ST_G3S5, ctrl_t'(8'h00), 1'b1, 1'b1, 1'b1}));
        // Zero and one tick settle delays both take a single tick
        plan.push_back(write_row(CFG_AON_SETTLE, 20'd0));
        plan.push_back(write_row(CFG_SUSCLK, 20'd1));
        plan.push_back(tick_row(8'h01, 1'b0, 1'b0, 1'b1, 1'b0));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b1));
        // S5 holds, then up to S3, back down to S5 and up again
        plan.push_back(tick_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0));
        plan.push_back(tick_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b1));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0));
        // S3 to S0 with rails arriving in stages
        plan.push_back(tick_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
        plan.push_back(tick_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b0));
        plan.push_back(tick_row(8'h3E, 1'b1, 1'b1, 1'b0, 1'b1));
        plan.push_back(write_row(CFG_PWROK_DELAY, 20'd0));
        plan.push_back(tick_row(8'hFE, 1'b1, 1'b1, 1'b1, 1'b0));
        plan.push_back(tick_row(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
        plan.push_back(tick_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
        // S0 back down to S3 through the S0S3 state
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b1));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0));
        plan.push_back(tick_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0));
        // A zero timeout expires on the first tick a wait is unmet
        plan.push_back(write_row(CFG_WAIT_TIMEOUT, 20'd0));
        plan.push_back(tick_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
        plan.push_back(tick_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b1));
        plan.push_back(checked_row(8'h3C, 1'b1, 1'b1, 1'b1, 1'b0,
                       '{ST_S3S0, ctrl_t'(8'b1101_1110), 1'b1, 1'b0, 1'b1}));
        plan.push_back(tick_row(8'h7F, 1'b1, 1'b1, 1'b0, 1'b0));

        // Hold reset, then release it once
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                drain();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
            begin
                drive_tick(plan[i].sample, plan[i].typed, plan[i].result);
                pace();
            end
        end

        // Random phases: each under its own register setting, extremes first.
        // The maximum pwrok delay can park the sequencer before S0 until the
        // next phase shortens it, which checks a delay cut short by a write.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    t_val = CNT_MAX;
                    p_val = '0;
                end
                1:
                begin
                    t_val = 20'd1;
                    p_val = CNT_MAX;
                end
                2:
                begin
                    t_val = '0;
                    p_val = 20'd1;
                end
                default:
                begin
                    t_val = REG_W'($urandom_range(1, 16));
                    p_val = REG_W'($urandom_range(0, 16));
                end
            endcase
            aon_val = (phase == 3) ? CNT_MAX : REG_W'($urandom_range(0, 20'hFFFFF));
            sus_val = (phase == 3) ? CNT_MAX : REG_W'($urandom_range(0, 20'hFFFFF));
            write_reg(CFG_WAIT_TIMEOUT, t_val);
            write_reg(CFG_AON_SETTLE, aon_val);
            write_reg(CFG_SUSCLK, sus_val);
            write_reg(CFG_PWROK_DELAY, p_val);

            for (n = 0; n < TICKS_PER_PHASE; n++)
            begin
                // Hold a sleep level for a while: 0 for S0, 1 for S3, 2 for S5
                if ($urandom_range(0, 11) == 0)
                    target = $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0)
                begin
                    s.slp_s3_n = 1'($urandom_range(0, 1));
                    s.slp_s5_n = 1'($urandom_range(0, 1));
                end
                else
                begin
                    s.slp_s3_n = (target == 0);
                    s.slp_s5_n = (target != 2);
                end
                // Rails mostly all good, sometimes one missing or random
                case ($urandom_range(0, 9))
                    0, 1:    s.rails_good = RAILS_W'($urandom_range(0, 255));
                    2:       s.rails_good = 8'hFF ^ (8'h01 << $urandom_range(0, 7));
                    default: s.rails_good = 8'hFF;
                endcase
                s.suswarn_n         = 1'($urandom_range(0, 1));
                s.backlight_request = 1'($urandom_range(0, 1));
                drive_tick(s, 1'b0, '0);
                pace();
            end
        end

        // Let the last results out, then watch for stray results before the summary
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d ticks of %0d sent, %0d register writes, %0d rail-wait timeouts.",
                 results_checked, ticks_sent, reg_writes, timeouts_seen);
        $display("Mismatches and unexpected results: %0d", fail_count);
        if (fail_count == 0)
            $display("[sleep_state_power_sequencer_core] OK");
        else
            $display("[sleep_state_power_sequencer_core] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("Run timed out with %0d results outstanding.", expected_ticks.size());
        $display("[sleep_state_power_sequencer_core] ERROR");
        $finish;
    end

endmodule
